// ===== rtl/core/bitmap_set_clear_find_zero_top_macros.svh =====
// Assertion helpers for the top file of the bitmap block.
`ifndef BITMAP_SET_CLEAR_FIND_ZERO_TOP_MACROS_SVH
`define BITMAP_SET_CLEAR_FIND_ZERO_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BMFZ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define BMFZ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/bmfz_pkg.sv =====
package bmfz_pkg;

  // Bitmap geometry.
  localparam int unsigned BITMAP_BITS = 4096;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned NUM_WORDS   = BITMAP_BITS / WORD_BITS;
  localparam int unsigned BIT_W       = $clog2(WORD_BITS);
  localparam int unsigned ADDR_W      = $clog2(NUM_WORDS);
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned SIZE_W      = 13;

  // Size register reset value and the largest usable search limit.
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] MAX_LIMIT  = SIZE_W'(BITMAP_BITS);

  // Configuration port decoding.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_BITMAP_SIZE = 1'b0;

  // Request action codes.
  typedef logic [1:0] action_t;
  localparam action_t ACT_SET   = 2'd0;
  localparam action_t ACT_CLEAR = 2'd1;
  localparam action_t ACT_TEST  = 2'd2;
  localparam action_t ACT_FIND  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic advance;
    logic update;
    logic finish_find;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_find;
    logic past_limit;
    logic scan_done;
  } sts_t;

  // Position of the lowest set bit, found by halving the word each step.
  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] v;
    logic [WORD_BITS-1:0] m;
    logic [BIT_W-1:0]     pos;
    v   = x;
    pos = '0;
    for (int s = BIT_W - 1; s >= 0; s--) begin
      m = WORD_BITS'((65'd1 << (1 << s)) - 65'd1);
      if ((v & m) == '0) begin
        pos[s] = 1'b1;
        v      = v >> (1 << s);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/bmfz_ctrl.sv =====
module bmfz_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bmfz_pkg::sts_t sts_i,
  output bmfz_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    IDLE,
    READ,
    UPDATE,
    SCAN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  // Next state and the command issued in the current state.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = READ;
        end
      end
      READ: begin
        if (sts_i.is_find) begin
          if (sts_i.past_limit) begin
            cmd_o.finish_find = 1'b1;
            state_d           = IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = SCAN;
          end
        end else begin
          state_d = UPDATE;
        end
      end
      UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = IDLE;
      end
      SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.finish_find = 1'b1;
          state_d           = IDLE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  // State register and the registered busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != IDLE);
    end
  end

  assign busy = busy_q;

endmodule

// ===== rtl/core/bmfz_dpath.sv =====
module bmfz_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    action_i,
  input  logic [bmfz_pkg::IDX_W-1:0]    bit_index_i,
  input  logic [bmfz_pkg::SIZE_W-1:0]   size_i,
  input  bmfz_pkg::cmd_t                cmd_i,
  output bmfz_pkg::sts_t                sts_o,
  output logic                          old_bit_o,
  output logic [bmfz_pkg::SIZE_W-1:0]   zero_index_o,
  output logic                          found_o,
  output logic                          done_o
);

  localparam int unsigned WB = bmfz_pkg::WORD_BITS;
  localparam int unsigned AW = bmfz_pkg::ADDR_W;
  localparam int unsigned BW = bmfz_pkg::BIT_W;
  localparam int unsigned IW = bmfz_pkg::IDX_W;
  localparam int unsigned SW = bmfz_pkg::SIZE_W;

  // Request registers.
  bmfz_pkg::action_t act_q;
  logic [IW-1:0]     idx_q;
  logic [SW-1:0]     limit_q;
  logic [SW-1:0]     limit_d;

  // Memory, its per-word valid bits and the read pipeline.
  logic [WB-1:0] mem [bmfz_pkg::NUM_WORDS];
  logic          ent_vld_q [bmfz_pkg::NUM_WORDS];
  logic [WB-1:0] mem_rd_q;
  logic          ent_vld_rd_q;
  logic [AW-1:0] ra_q;
  logic [AW-1:0] ea_q;
  logic          rd_vld_q;

  // Result registers.
  logic          old_bit_q;
  logic [SW-1:0] zero_index_q;
  logic          found_q;
  logic          done_q;

  // Evaluation of the word that has just been read.
  logic [WB-1:0] word;
  logic [WB-1:0] start_mask;
  logic [WB-1:0] free;
  logic [BW-1:0] pos;
  logic [IW-1:0] cand;
  logic          hit;
  logic          cand_ok;
  logic [SW-1:0] limit_m1;
  logic [AW-1:0] last_w;
  logic [WB-1:0] wword;
  logic          mem_we;

  // A size beyond the bitmap is clamped to the bitmap length.
  assign limit_d = (size_i > bmfz_pkg::MAX_LIMIT) ? bmfz_pkg::MAX_LIMIT : size_i;

  // Words never written read as all free.
  assign word = ent_vld_rd_q ? mem_rd_q : '0;

  // In the start word, bits below the start offset are not candidates.
  assign start_mask = (ea_q == idx_q[IW-1:BW]) ? ({WB{1'b1}} << idx_q[BW-1:0]) : '1;
  assign free       = ~word & start_mask;
  assign pos        = bmfz_pkg::lowest_one(free);
  assign cand       = {ea_q, pos};
  assign hit        = rd_vld_q && (free != '0);
  assign cand_ok    = hit && ({1'b0, cand} < limit_q);
  assign limit_m1   = limit_q - SW'(1);
  assign last_w     = limit_m1[IW-1:BW];

  // Status to the controller.
  assign sts_o.is_find    = (act_q == bmfz_pkg::ACT_FIND);
  assign sts_o.past_limit = ({1'b0, idx_q} >= limit_q);
  assign sts_o.scan_done  = rd_vld_q && ((free != '0) || (ea_q >= last_w));

  // Word written back by set or clear.
  always_comb begin
    wword                 = word;
    wword[idx_q[BW-1:0]]  = (act_q == bmfz_pkg::ACT_SET);
  end

  assign mem_we = cmd_i.update && (act_q != bmfz_pkg::ACT_TEST);

  // Request capture and read address stepping.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= bmfz_pkg::action_t'(action_i);
      idx_q   <= bit_index_i;
      limit_q <= limit_d;
      ra_q    <= bit_index_i[IW-1:BW];
    end else if (cmd_i.advance) begin
      ra_q <= ra_q + AW'(1);
    end
    ea_q <= ra_q;
  end

  // Memory array: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q[IW-1:BW]] <= wword;
    end
    mem_rd_q <= mem[ra_q];
  end

  // Valid bits, cleared at reset, and the read valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(bmfz_pkg::NUM_WORDS); i++) begin
        ent_vld_q[i] <= 1'b0;
      end
      ent_vld_rd_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_vld_q[idx_q[IW-1:BW]] <= 1'b1;
      end
      ent_vld_rd_q <= ent_vld_q[ra_q];
      rd_vld_q     <= cmd_i.advance;
      done_q       <= cmd_i.update || cmd_i.finish_find;
    end
  end

  // Result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      old_bit_q    <= word[idx_q[BW-1:0]];
      zero_index_q <= '0;
      found_q      <= 1'b0;
    end else if (cmd_i.finish_find) begin
      old_bit_q    <= 1'b0;
      zero_index_q <= cand_ok ? {1'b0, cand} : limit_q;
      found_q      <= cand_ok;
    end
  end

  assign old_bit_o    = old_bit_q;
  assign zero_index_o = zero_index_q;
  assign found_o      = found_q;
  assign done_o       = done_q;

endmodule

// ===== rtl/core/bitmap_set_clear_find_zero_top.sv =====
// Allocation bitmap of 4096 bits held in a memory of 128 words of 32 bits,
// all free after reset. A command word is taken when start is high and busy
// is low; its result word appears for exactly one cycle with done_o high,
// and busy is low again in that cycle. Set and clear rewrite the addressed
// word with the bit changed; test only reads it. Find-next-zero walks no
// words when the start index is at or past the size, else walks words from
// the start word to the one holding the last bit below the size, stopping at
// the first with a free bit; the memory yields one word per cycle. The user
// writes the size register through the configuration port while the block
// is idle; the block does not enforce this. A size above 4096 acts as 4096.
`include "bitmap_set_clear_find_zero_top_macros.svh"

module bitmap_set_clear_find_zero_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bmfz_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // Command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action_i,
  input  logic [bmfz_pkg::IDX_W-1:0]          bit_index_i,
  // Result channel
  output logic                                done_o,
  output logic                                old_bit_o,
  output logic [bmfz_pkg::SIZE_W-1:0]         zero_index_o,
  output logic                                found_o
);

  localparam int unsigned SW = bmfz_pkg::SIZE_W;
  localparam int unsigned AW = bmfz_pkg::CFG_ADDR_W;

  logic [SW-1:0]  size_q;
  logic           reg_sel;
  logic           cfg_we;
  bmfz_pkg::cmd_t cmd;
  bmfz_pkg::sts_t sts;

  // Register decoding: one register per 32-bit word.
  assign reg_sel = (paddr[AW-1:2] == bmfz_pkg::REG_BITMAP_SIZE);
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(size_q) : '0;

  // Bitmap size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= bmfz_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_q <= pwdata[SW-1:0];
    end
  end

  // Sequencer.
  bmfz_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Memory and search logic.
  bmfz_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (action_i),
    .bit_index_i  (bit_index_i),
    .size_i       (size_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .old_bit_o    (old_bit_o),
    .zero_index_o (zero_index_o),
    .found_o      (found_o),
    .done_o       (done_o)
  );

  // Checks on the sequencing and on the search result.
  `BMFZ_ASSERT(a_busy_after_accept, (start && !busy) |=> busy, "busy did not rise after a command word")
  `BMFZ_ASSERT(a_single_strobe, done_o |=> !done_o, "result strobe lasted more than one cycle")
  `BMFZ_NEVER(a_strobe_while_busy, done_o && busy, "result strobe while busy")
  `BMFZ_NEVER(a_found_below_size, done_o && found_o && (zero_index_o >= size_q), "found index not below size")

endmodule
